>>> hw/rtl/dncd_pkg.sv
`timescale 1ns / 1ps

package dncd_pkg;

    localparam int DAY_BITS      = 22;
    localparam int FRACTION_BITS = 32;
    localparam int YEAR_BITS     = 14;
    localparam int STAGES        = 8;

    localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
    // one era up, minus the 61 days from January 1 to March 1 of year 0
    localparam logic [17:0] ERA_OFFSET   = 18'd146036;

    localparam logic [26:0] MS_PER_DAY   = 27'd86400000;
    localparam logic [21:0] MS_PER_HOUR  = 22'd3600000;
    localparam logic [15:0] MS_PER_MIN   = 16'd60000;
    localparam logic [9:0]  MS_PER_SEC   = 10'd1000;
    // 86400000 / 1024
    localparam logic [16:0] FRAC_SCALE   = 17'd84375;

    typedef struct packed {
        logic [DAY_BITS-1:0]      day_number;
        logic [FRACTION_BITS-1:0] day_fraction;
    } stamp_t;

    typedef struct packed {
        logic [YEAR_BITS-1:0] year;
        logic [3:0]           month;
        logic [4:0]           day_of_month;
    } cal_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [9:0] milliseconds;
    } tod_t;

    typedef struct packed {
        logic [YEAR_BITS-1:0] year;
        logic [3:0]           month;
        logic [4:0]           day_of_month;
        logic [4:0]           hours;
        logic [5:0]           minutes;
        logic [5:0]           seconds;
        logic [9:0]           milliseconds;
    } date_t;

    // first day-of-year of each March-based month
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start;
        unique case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

>>> hw/rtl/day_number_to_calendar_date.sv
`timescale 1ns / 1ps

// channel  | valid        | stall        | payload
// ---------+--------------+--------------+-----------------------------------
// request  | stamp_valid  | stamp_stall  | stamp (day_number, day_fraction)
// result   | date_valid   | date_stall   | date (year .. milliseconds)
//
// Eight register stages lie between a taken request and date_valid.
// One request per cycle sustained while date_stall is low; constant divisions
// are reciprocal multiplies; the date and time-of-day paths run side by side.
// rst_n clears only the stage valid bits.
// A stalled result holds its stage; earlier stages keep filling empty slots,
// and stamp_stall rises only when every stage is full.

module day_number_to_calendar_date (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             stamp_valid,
    output logic             stamp_stall,
    input  dncd_pkg::stamp_t stamp,
    output logic             date_valid,
    input  logic             date_stall,
    output dncd_pkg::date_t  date
);
    import dncd_pkg::*;

    logic [STAGES-1:0] adv;
    cal_t              cal;
    tod_t              tod;

    dncd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .stamp_valid (stamp_valid),
        .stamp_stall (stamp_stall),
        .date_valid  (date_valid),
        .date_stall  (date_stall),
        .adv         (adv)
    );

    dncd_date u_date (
        .clk   (clk),
        .adv   (adv),
        .stamp (stamp),
        .cal   (cal)
    );

    dncd_time u_time (
        .clk   (clk),
        .adv   (adv),
        .stamp (stamp),
        .tod   (tod)
    );

    always_comb
    begin
        date.year         = cal.year;
        date.month        = cal.month;
        date.day_of_month = cal.day_of_month;
        date.hours        = tod.hours;
        date.minutes      = tod.minutes;
        date.seconds      = tod.seconds;
        date.milliseconds = tod.milliseconds;
    end

endmodule

>>> hw/rtl/dncd_ctrl.sv
`timescale 1ns / 1ps

module dncd_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        stamp_valid,
    output logic                        stamp_stall,
    output logic                        date_valid,
    input  logic                        date_stall,
    output logic [dncd_pkg::STAGES-1:0] adv
);
    import dncd_pkg::*;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;

    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || !date_stall;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = stamp_valid;
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (adv[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign stamp_stall = !adv[0];
    assign date_valid  = valid_reg[STAGES-1];

endmodule

>>> hw/rtl/dncd_date.sv
`timescale 1ns / 1ps

module dncd_date (
    input  logic                        clk,
    input  logic [dncd_pkg::STAGES-1:0] adv,
    input  dncd_pkg::stamp_t            stamp,
    output dncd_pkg::cal_t              cal
);
    import dncd_pkg::*;

    // quotients by constants: q = (x * M) >> S, exact for x < 2^N
    localparam int Z_W    = DAY_BITS + 1;
    localparam int ERA_S  = Z_W + $clog2(DAYS_PER_ERA);
    localparam logic [Z_W:0] ERA_M = (Z_W+1)'(((64'd1 << ERA_S)
        + 64'(DAYS_PER_ERA) - 64'd1) / 64'(DAYS_PER_ERA));
    localparam int ERA_W  = $clog2((((64'd1 << DAY_BITS) + 64'(ERA_OFFSET))
        / 64'(DAYS_PER_ERA)) + 64'd1);

    localparam int DOE_W  = $clog2(DAYS_PER_ERA);
    localparam logic [DOE_W-1:0] DOE_LAST = DOE_W'(DAYS_PER_ERA - 18'd1);

    localparam int D4Y     = 1460;
    localparam int D4Y_S   = DOE_W + $clog2(D4Y);
    localparam logic [DOE_W:0] D4Y_M = (DOE_W+1)'(((64'd1 << D4Y_S) + 64'(D4Y) - 64'd1)
        / 64'(D4Y));
    localparam int Q1_W    = 7;

    localparam int D100Y   = 36524;
    localparam int D100Y_S = DOE_W + $clog2(D100Y);
    localparam logic [DOE_W:0] D100Y_M = (DOE_W+1)'(((64'd1 << D100Y_S) + 64'(D100Y)
        - 64'd1) / 64'(D100Y));
    localparam int Q2_W    = 3;

    localparam int D1Y     = 365;
    localparam int D1Y_S   = DOE_W + $clog2(D1Y);
    localparam logic [DOE_W:0] D1Y_M = (DOE_W+1)'(((64'd1 << D1Y_S) + 64'(D1Y) - 64'd1)
        / 64'(D1Y));
    localparam int YOE_W   = 9;

    localparam int Y100    = 100;
    localparam int Y100_S  = YOE_W + $clog2(Y100);
    localparam logic [YOE_W:0] Y100_M = (YOE_W+1)'(((64'd1 << Y100_S) + 64'(Y100)
        - 64'd1) / 64'(Y100));
    localparam int YQ_W    = 2;

    localparam int DOY_W   = 9;
    localparam int V_W     = 11;
    localparam int DMON    = 153;
    localparam int DMON_S  = V_W + $clog2(DMON);
    localparam logic [V_W:0] DMON_M = (V_W+1)'(((64'd1 << DMON_S) + 64'(DMON) - 64'd1)
        / 64'(DMON));
    localparam int MP_W    = 4;
    localparam logic [MP_W-1:0] MP_JAN = 4'd10;

    localparam int YEARS_PER_ERA = 400;

    // stage 0
    logic [DAY_BITS-1:0] dn;
    logic [Z_W-1:0]      z;
    logic [2*Z_W:0]      era_prod;
    logic [Z_W-1:0]      z0_reg;
    logic [ERA_W-1:0]    era0_reg;
    // stage 1
    logic [DOE_W-1:0]    doe1_reg;
    logic [ERA_W-1:0]    era1_reg;
    // stage 2
    logic [2*DOE_W:0]    p4y;
    logic [2*DOE_W:0]    p100y;
    logic [DOE_W-1:0]    doe2_reg;
    logic [ERA_W-1:0]    era2_reg;
    logic [Q1_W-1:0]     q1_reg;
    logic [Q2_W-1:0]     q2_reg;
    logic                q3_reg;
    // stage 3
    logic [DOE_W-1:0]    t;
    logic [2*DOE_W:0]    p1y;
    logic [DOE_W-1:0]    doe3_reg;
    logic [ERA_W-1:0]    era3_reg;
    logic [YOE_W-1:0]    yoe3_reg;
    // stage 4
    logic [2*YOE_W:0]    p100;
    logic [DOE_W-1:0]    base;
    logic [DOY_W-1:0]    doy4_reg;
    logic [YOE_W-1:0]    yoe4_reg;
    logic [ERA_W-1:0]    era4_reg;
    // stage 5
    logic [V_W-1:0]      v;
    logic [2*V_W:0]      pmon;
    logic [MP_W-1:0]     mp5_reg;
    logic [DOY_W-1:0]    doy5_reg;
    logic [YOE_W-1:0]    yoe5_reg;
    logic [ERA_W-1:0]    era5_reg;
    // stage 6, 7
    cal_t                cal_next;
    logic                wrap;
    cal_t                cal6_reg;
    cal_t                cal7_reg;

    always_comb
    begin
        dn = stamp.day_number;
        if (dn == '0)
        begin
            dn = DAY_BITS'(1);
        end
        z        = Z_W'(dn) + Z_W'(ERA_OFFSET);
        era_prod = (2*Z_W+1)'(z) * (2*Z_W+1)'(ERA_M);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            z0_reg   <= z;
            era0_reg <= era_prod[ERA_S +: ERA_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            doe1_reg <= DOE_W'(z0_reg - Z_W'(era0_reg) * Z_W'(DAYS_PER_ERA));
            era1_reg <= era0_reg;
        end
    end

    assign p4y   = (2*DOE_W+1)'(doe1_reg) * (2*DOE_W+1)'(D4Y_M);
    assign p100y = (2*DOE_W+1)'(doe1_reg) * (2*DOE_W+1)'(D100Y_M);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            doe2_reg <= doe1_reg;
            era2_reg <= era1_reg;
            q1_reg   <= p4y[D4Y_S +: Q1_W];
            q2_reg   <= p100y[D100Y_S +: Q2_W];
            q3_reg   <= (doe1_reg == DOE_LAST);
        end
    end

    assign t   = doe2_reg - DOE_W'(q1_reg) + DOE_W'(q2_reg) - DOE_W'(q3_reg);
    assign p1y = (2*DOE_W+1)'(t) * (2*DOE_W+1)'(D1Y_M);

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            doe3_reg <= doe2_reg;
            era3_reg <= era2_reg;
            yoe3_reg <= p1y[D1Y_S +: YOE_W];
        end
    end

    assign p100 = (2*YOE_W+1)'(yoe3_reg) * (2*YOE_W+1)'(Y100_M);
    assign base = DOE_W'(yoe3_reg) * DOE_W'(D1Y) + DOE_W'(yoe3_reg >> 2)
        - DOE_W'(p100[Y100_S +: YQ_W]);

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            doy4_reg <= DOY_W'(doe3_reg - base);
            yoe4_reg <= yoe3_reg;
            era4_reg <= era3_reg;
        end
    end

    assign v    = V_W'(doy4_reg) * V_W'(5) + V_W'(2);
    assign pmon = (2*V_W+1)'(v) * (2*V_W+1)'(DMON_M);

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            mp5_reg  <= pmon[DMON_S +: MP_W];
            doy5_reg <= doy4_reg;
            yoe5_reg <= yoe4_reg;
            era5_reg <= era4_reg;
        end
    end

    always_comb
    begin
        wrap = (mp5_reg >= MP_JAN);
        if (wrap)
        begin
            cal_next.month = mp5_reg - 4'd9;
        end
        else
        begin
            cal_next.month = mp5_reg + 4'd3;
        end
        cal_next.day_of_month = 5'(doy5_reg - month_start(mp5_reg) + DOY_W'(1));
        cal_next.year = YEAR_BITS'(yoe5_reg)
            + YEAR_BITS'(era5_reg) * YEAR_BITS'(YEARS_PER_ERA)
            + YEAR_BITS'(wrap) - YEAR_BITS'(YEARS_PER_ERA);
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            cal6_reg <= cal_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            cal7_reg <= cal6_reg;
        end
    end

    assign cal = cal7_reg;

endmodule

>>> hw/rtl/dncd_time.sv
`timescale 1ns / 1ps

module dncd_time (
    input  logic                        clk,
    input  logic [dncd_pkg::STAGES-1:0] adv,
    input  dncd_pkg::stamp_t            stamp,
    output dncd_pkg::tod_t              tod
);
    import dncd_pkg::*;

    localparam int P_W    = FRACTION_BITS + 17;
    localparam int RND_SH = FRACTION_BITS - 10;
    localparam logic [P_W:0] RND_HALF = (P_W+1)'(64'd1 << (FRACTION_BITS - 11));

    localparam int MS_W   = 27;
    localparam int HR_S   = MS_W + $clog2(MS_PER_HOUR);
    localparam logic [MS_W:0] HR_M = (MS_W+1)'(((64'd1 << HR_S) + 64'(MS_PER_HOUR)
        - 64'd1) / 64'(MS_PER_HOUR));

    localparam int R1_W   = 22;
    localparam int MN_S   = R1_W + $clog2(MS_PER_MIN);
    localparam logic [R1_W:0] MN_M = (R1_W+1)'(((64'd1 << MN_S) + 64'(MS_PER_MIN)
        - 64'd1) / 64'(MS_PER_MIN));

    localparam int R2_W   = 16;
    localparam int SC_S   = R2_W + $clog2(MS_PER_SEC);
    localparam logic [R2_W:0] SC_M = (R2_W+1)'(((64'd1 << SC_S) + 64'(MS_PER_SEC)
        - 64'd1) / 64'(MS_PER_SEC));

    logic [P_W-1:0]    prod0_reg;
    logic [P_W:0]      rnd;
    logic [P_W:0]      ms_raw;
    logic [MS_W-1:0]   ms;
    logic [MS_W-1:0]   ms1_reg;
    logic [2*MS_W:0]   phr;
    logic [MS_W-1:0]   ms2_reg;
    logic [4:0]        hr2_reg;
    logic [R1_W-1:0]   r1_3_reg;
    logic [4:0]        hr3_reg;
    logic [2*R1_W:0]   pmn;
    logic [R1_W-1:0]   r1_4_reg;
    logic [5:0]        mn4_reg;
    logic [4:0]        hr4_reg;
    logic [R2_W-1:0]   r2_5_reg;
    logic [5:0]        mn5_reg;
    logic [4:0]        hr5_reg;
    logic [2*R2_W:0]   psc;
    logic [R2_W-1:0]   r2_6_reg;
    logic [5:0]        sc6_reg;
    logic [5:0]        mn6_reg;
    logic [4:0]        hr6_reg;
    tod_t              tod7_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prod0_reg <= P_W'(stamp.day_fraction) * P_W'(FRAC_SCALE);
        end
    end

    always_comb
    begin
        rnd    = (P_W+1)'(prod0_reg) + RND_HALF;
        ms_raw = rnd >> RND_SH;
        if (ms_raw >= (P_W+1)'(MS_PER_DAY))
        begin
            ms = MS_PER_DAY - 27'd1;
        end
        else
        begin
            ms = MS_W'(ms_raw);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            ms1_reg <= ms;
        end
    end

    assign phr = (2*MS_W+1)'(ms1_reg) * (2*MS_W+1)'(HR_M);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            ms2_reg <= ms1_reg;
            hr2_reg <= phr[HR_S +: 5];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            r1_3_reg <= R1_W'(ms2_reg - MS_W'(hr2_reg) * MS_W'(MS_PER_HOUR));
            hr3_reg  <= hr2_reg;
        end
    end

    assign pmn = (2*R1_W+1)'(r1_3_reg) * (2*R1_W+1)'(MN_M);

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            r1_4_reg <= r1_3_reg;
            mn4_reg  <= pmn[MN_S +: 6];
            hr4_reg  <= hr3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            r2_5_reg <= R2_W'(r1_4_reg - R1_W'(mn4_reg) * R1_W'(MS_PER_MIN));
            mn5_reg  <= mn4_reg;
            hr5_reg  <= hr4_reg;
        end
    end

    assign psc = (2*R2_W+1)'(r2_5_reg) * (2*R2_W+1)'(SC_M);

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            r2_6_reg <= r2_5_reg;
            sc6_reg  <= psc[SC_S +: 6];
            mn6_reg  <= mn5_reg;
            hr6_reg  <= hr5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            tod7_reg.hours        <= hr6_reg;
            tod7_reg.minutes      <= mn6_reg;
            tod7_reg.seconds      <= sc6_reg;
            tod7_reg.milliseconds <= 10'(r2_6_reg - R2_W'(sc6_reg) * R2_W'(MS_PER_SEC));
        end
    end

    assign tod = tod7_reg;

endmodule

>>> verif/day_number_to_calendar_date_test.sv
`timescale 1ns / 1ps

module day_number_to_calendar_date_test;

    import dncd_pkg::*;

    localparam longint unsigned ERA_DAYS    = 146097;
    localparam longint unsigned CENTURY_DAYS = 36524;
    localparam longint unsigned DAY_MS      = 86400000;
    localparam int unsigned     MAX_DAY     = (1 << DAY_BITS) - 1;
    localparam int unsigned     HOLD_CYCLES = 80;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   stamp_valid = 1'b0;
    logic   stamp_stall;
    stamp_t stamp = '0;
    logic   date_valid;
    logic   date_stall = 1'b0;
    date_t  date;

    date_t  date_q[$];
    int     mismatches = 0;
    int     sent = 0;
    int     checked = 0;
    int     input_stalls = 0;
    int     holds_done = 0;

    // sender pacing
    bit     steady = 1'b0;
    int     burst_left = 0;

    // receiver pattern
    bit     hold_req = 1'b0;
    int     hold_left = 0;
    int     mode = 0;
    int     mode_left = 0;

    day_number_to_calendar_date dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .stamp_valid (stamp_valid),
        .stamp_stall (stamp_stall),
        .stamp       (stamp),
        .date_valid  (date_valid),
        .date_stall  (date_stall),
        .date        (date)
    );

    always #5 clk = ~clk;

    function automatic date_t civil_date(input stamp_t s);
        longint unsigned dn, fr, z, era, doe, yoe, y, doy, mp, d, m, ms;
        date_t r;
        dn = s.day_number;
        fr = s.day_fraction;
        if (dn == 0)
            dn = 1;
        // March-based count, lifted one era so it stays positive
        z   = dn - 61 + ERA_DAYS;
        era = z / ERA_DAYS;
        doe = z - era * ERA_DAYS;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        y   = yoe + era * 400;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        d   = doy - (153 * mp + 2) / 5 + 1;
        if (mp < 10)
        begin
            m = mp + 3;
        end
        else
        begin
            m = mp - 9;
            y = y + 1;
        end
        y = y - 400;
        ms = (fr * 64'd84375 + (64'd1 << (FRACTION_BITS - 11))) >> (FRACTION_BITS - 10);
        if (ms >= DAY_MS)
            ms = DAY_MS - 1;
        r.year         = 14'(y);
        r.month        = 4'(m);
        r.day_of_month = 5'(d);
        r.hours        = 5'(ms / 3600000);
        r.minutes      = 6'((ms / 60000) % 60);
        r.seconds      = 6'((ms / 1000) % 60);
        r.milliseconds = 10'(ms % 1000);
        return r;
    endfunction

    task automatic idle_gap();
        int n;
        if (steady)
            return;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        n = $urandom_range(1, 7);
        repeat (n)
        begin
            @(negedge clk);
            stamp_valid <= 1'b0;
        end
        // occasional long bursts with no gaps
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    endtask

    task automatic send_stamp(input logic [DAY_BITS-1:0] dn, input logic [FRACTION_BITS-1:0] fr);
        stamp_t s;
        s.day_number   = dn;
        s.day_fraction = fr;
        @(negedge clk);
        stamp       <= s;
        stamp_valid <= 1'b1;
        @(posedge clk);
        while (stamp_stall !== 1'b0)
            @(posedge clk);
        date_q.push_back(civil_date(s));
        sent++;
        idle_gap();
    endtask

    // receiver: long hold-offs on request, otherwise a changing stall pattern
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            date_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0: date_stall <= 1'b0;
                1: date_stall <= ($urandom_range(0, 99) < 30);
                2: date_stall <= ($urandom_range(0, 99) < 75);
                default: date_stall <= ~date_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin
        date_t want;
        if (rst_n && stamp_valid === 1'b1 && stamp_stall === 1'b1)
            input_stalls++;
        if (rst_n && date_valid === 1'b1 && date_stall === 1'b0)
        begin
            checked++;
            if (date_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected date %0d-%0d-%0d %0d:%0d:%0d.%0d", $realtime,
                             date.year, date.month, date.day_of_month, date.hours,
                             date.minutes, date.seconds, date.milliseconds);
            end
            else
            begin
                want = date_q.pop_front();
                if (date.year !== want.year || date.month !== want.month ||
                    date.day_of_month !== want.day_of_month || date.hours !== want.hours ||
                    date.minutes !== want.minutes || date.seconds !== want.seconds ||
                    date.milliseconds !== want.milliseconds)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: expected %0d-%0d-%0d %0d:%0d:%0d.%0d got %0d-%0d-%0d %0d:%0d:%0d.%0d",
                                 $realtime, want.year, want.month, want.day_of_month,
                                 want.hours, want.minutes, want.seconds, want.milliseconds,
                                 date.year, date.month, date.day_of_month, date.hours,
                                 date.minutes, date.seconds, date.milliseconds);
                end
            end
        end
    end

    task automatic test_calendar_edges();
        send_stamp(22'd0, 32'h0000_0000);        // day zero saturates to day 1
        send_stamp(22'd1, 32'h0000_0000);
        send_stamp(22'd31, 32'h1234_5678);       // Jan 31 / Feb 1
        send_stamp(22'd32, 32'h8765_4321);
        send_stamp(22'd60, 32'h4000_0000);       // leap day of year 0
        send_stamp(22'd61, 32'hC000_0000);
        send_stamp(22'd366, 32'hFFFF_FFFF);      // year 0 to year 1
        send_stamp(22'd367, 32'h0000_0001);
        send_stamp(22'd36584, 32'h2AAA_AAAA);    // century year 100, no leap day
        send_stamp(22'd36585, 32'h5555_5555);
        send_stamp(22'd146157, 32'h8000_0000);   // year 400 leap day
        send_stamp(22'd146158, 32'h7FFF_FFFF);
        send_stamp(22'd730485, 32'hFFFF_FFF0);   // 1999-12-31 / 2000-01-01
        send_stamp(22'd730486, 32'h0000_0000);
        send_stamp(22'(MAX_DAY - 1), 32'hFFFF_FFE0);
        send_stamp(22'(MAX_DAY), 32'hFFFF_FFFF);
    endtask

    task automatic test_time_edges();
        send_stamp(22'd100000, 32'h0020_0000);   // exact half millisecond rounds up
        send_stamp(22'd100000, 32'h001F_FFFF);
        send_stamp(22'd100001, 32'hFFFF_FFE7);   // just below saturation
        send_stamp(22'd100001, 32'hFFFF_FFE8);
        send_stamp(22'd100002, 32'hFFFF_FC00);
        send_stamp(22'd100002, 32'h0000_0031);
        send_stamp(22'd100003, 32'hAAAA_AAAA);
    endtask

    task automatic test_backpressure();
        int i;
        repeat (2)
        begin
            steady = 1'b1;
            @(negedge clk);
            stamp_valid <= 1'b0;
            hold_req = 1'b1;
            for (i = 0; i < 40; i++)
                send_stamp(22'($urandom_range(0, MAX_DAY)), $urandom());
            steady = 1'b0;
            @(negedge clk);
            stamp_valid <= 1'b0;
            while (hold_left != 0)
                @(posedge clk);
        end
    endtask

    task automatic test_random_stream(input int count);
        int i, base, kind;
        logic [DAY_BITS-1:0] dn;
        logic [FRACTION_BITS-1:0] fr;
        for (i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
                dn = 22'($urandom_range(0, MAX_DAY));
            else if (kind < 6)
            begin
                base = int'($urandom_range(0, 28) * ERA_DAYS) + int'($urandom_range(0, 800));
                dn   = 22'((base < 400) ? 0 : base - 400);
            end
            else if (kind < 8)
                dn = 22'($urandom_range(1, 114) * CENTURY_DAYS + $urandom_range(0, 800) - 400);
            else
                dn = 22'($urandom_range(0, 800));
            case ($urandom_range(0, 7))
                0: fr = 32'hFFFF_FFFF - $urandom_range(0, 8191);
                1: fr = $urandom_range(0, 8191);
                2: fr = {10'($urandom()), 1'b1, 21'h0} + $urandom_range(0, 2) - 1;
                default: fr = $urandom();
            endcase
            send_stamp(dn, fr);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_calendar_edges();
        test_time_edges();
        test_backpressure();
        test_random_stream(1850);
        @(negedge clk);
        stamp_valid <= 1'b0;
        while (date_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d timestamps, checked %0d dates, %0d mismatches.",
                 sent, checked, mismatches);
        $display("Input stalled %0d cycles over %0d long output hold-offs.",
                 input_stalls, holds_done);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d dates outstanding.", date_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/dncd_pkg.sv
hw/rtl/dncd_ctrl.sv
hw/rtl/dncd_date.sv
hw/rtl/dncd_time.sv
hw/rtl/day_number_to_calendar_date.sv
verif/day_number_to_calendar_date_test.sv
